// ----- rtl/json_string_unescape_unit_assert.svh -----
// Assertion macros for the JSON string unescape unit.
`ifndef JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define JSU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JSU_ASSERT_IMPLY(lbl, ante, cons, msg)
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/jsu_pkg.sv -----
// Shared types, codes and helper functions for the JSON string unescape unit.
package jsu_pkg;

    // front phase codes
    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_BODY = 4'd1;
    localparam logic [3:0] PH_ESC  = 4'd2;
    localparam logic [3:0] PH_HEX  = 4'd3;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // main action of a command
    localparam logic [1:0] MAIN_NONE = 2'd0;
    localparam logic [1:0] MAIN_CP   = 2'd1;
    localparam logic [1:0] MAIN_END  = 2'd2;
    localparam logic [1:0] MAIN_ERR  = 2'd3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] HI_SURR_LO = 16'hD800;
    localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SURR_LO = 16'hDC00;
    localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // one decoded input byte: optional flush of a held surrogate, then a main action
    typedef struct packed {
        logic        flush;
        logic [15:0] flush_cp;
        logic [1:0]  main;
        logic [20:0] cp;
        logic [2:0]  cp_len;
        logic [2:0]  total;
    } cmd_t;

    typedef struct packed {
        logic [3:0] phase;
        logic       held_valid;
    } front_status_t;

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66)
            r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46)
            r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    // short escapes: {ok, mapped byte}
    function automatic logic [8:0] esc_map(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h6E:    r = {1'b1, 8'h0A};
            8'h74:    r = {1'b1, 8'h09};
            8'h72:    r = {1'b1, 8'h0D};
            8'h62:    r = {1'b1, 8'h08};
            8'h66:    r = {1'b1, 8'h0C};
            CH_SLASH: r = {1'b1, CH_SLASH};
            CH_BSL:   r = {1'b1, CH_BSL};
            CH_QUOTE: r = {1'b1, CH_QUOTE};
            default:  r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] r;
        if (cp < 21'h80)
            r = 3'd1;
        else if (cp < 21'h800)
            r = 3'd2;
        else if (cp < 21'h10000)
            r = 3'd3;
        else
            r = 3'd4;
        return r;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                             input logic [1:0] j);
        logic [7:0] r;
        r = {2'b10, cp[5:0]};
        case (len)
            3'd1: r = cp[7:0];
            3'd2: begin
                if (j == 2'd0)
                    r = {3'b110, cp[10:6]};
            end
            3'd3: begin
                if (j == 2'd0)
                    r = {4'b1110, cp[15:12]};
                else if (j == 2'd1)
                    r = {2'b10, cp[11:6]};
            end
            default: begin
                if (j == 2'd0)
                    r = {5'b11110, cp[20:18]};
                else if (j == 2'd1)
                    r = {2'b10, cp[17:12]};
                else if (j == 2'd2)
                    r = {2'b10, cp[11:6]};
            end
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/json_string_unescape_unit.sv -----
// Top level of the JSON string unescape unit.
//
// Feed the bytes of one JSON string literal, opening quote first, through the push/full
// side; decoded UTF-8 bytes come back through the empty/pop side, followed by one end
// word at the closing quote, or by one error word on a missing opening quote, a bad
// escape, a bad hex digit or a raw NUL (the string should then be dropped). Every input
// byte that produces output marks its final word with last. The front end takes one
// byte per cycle while full is low and turns each byte that yields words into a
// command; a four-entry command queue holds these until the back end expands each
// into one to six words at one word per cycle while pop is held, so sustained
// throughput is one byte per cycle for plain text and drops only while \u escapes or
// flushed surrogates produce several words each. full rises only when that queue is
// full. A word reaches the result side through the command queue and the back end's
// current-command register, once the back end is done with the commands ahead of it.
// Opening quotes, backslashes, partial hex digits and a held high surrogate produce no words.
`include "json_string_unescape_unit_assert.svh"

module json_string_unescape_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last
);

    logic                  accept;
    logic                  cmd_push;
    jsu_pkg::cmd_t         cmd;
    jsu_pkg::cmd_t         head;
    jsu_pkg::front_status_t fst;
    logic                  q_empty;
    logic                  head_pop;

    // a byte is taken whenever the queue has room, whether or not it yields words
    assign accept = push && !full;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .cmd_push (cmd_push),
        .cmd      (cmd),
        .status   (fst)
    );

    jsu_cmd_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_push),
        .wr_data (cmd),
        .rd      (head_pop),
        .rd_data (head),
        .full    (full),
        .empty   (q_empty)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (q_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .kind       (kind),
        .last       (last)
    );

    // end and error words always close their byte's group
    `JSU_ASSERT_IMPLY(a_ctrl_is_last, !empty && kind != jsu_pkg::KIND_DATA, last, "no last")
    // an idle front end never keeps a surrogate
    `JSU_ASSERT_IMPLY(a_idle_no_held, fst.phase == jsu_pkg::PH_IDLE, !fst.held_valid, "held")
    // the expander picks up queued work straight away
    `JSU_ASSERT_NEXT(a_back_loads, empty && !q_empty, !empty, "expander idle with work queued")

endmodule

// ----- rtl/jsu_front.sv -----
// Front end: escape phase tracking, hex collection, surrogate pairing, command build.
module jsu_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            in_byte,
    output logic                  cmd_push,
    output jsu_pkg::cmd_t         cmd,
    output jsu_pkg::front_status_t status
);

    logic [3:0]  phase_reg,     phase_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic [2:0]  hex_count_reg, hex_count_next;
    logic [15:0] held_high_reg, held_high_next;
    logic        held_valid_reg, held_valid_next;

    logic        has_result;
    logic        verbatim;
    logic [4:0]  hd;
    logic [8:0]  em;
    logic [15:0] v;

    always_comb
    begin
        phase_next      = phase_reg;
        hex_value_next  = hex_value_reg;
        hex_count_next  = hex_count_reg;
        held_high_next  = held_high_reg;
        held_valid_next = held_valid_reg;
        has_result      = 1'b0;
        verbatim        = 1'b0;
        cmd             = '0;
        hd              = jsu_pkg::hex_digit(in_byte);
        em              = jsu_pkg::esc_map(in_byte);
        v               = {hex_value_reg[11:0], hd[3:0]};

        unique case (phase_reg)
            jsu_pkg::PH_BODY:
            begin
                if (in_byte == jsu_pkg::CH_QUOTE)
                begin
                    cmd.flush       = held_valid_reg;
                    cmd.flush_cp    = held_high_reg;
                    cmd.main        = jsu_pkg::MAIN_END;
                    has_result      = 1'b1;
                    phase_next      = jsu_pkg::PH_IDLE;
                    hex_value_next  = '0;
                    hex_count_next  = '0;
                    held_high_next  = '0;
                    held_valid_next = 1'b0;
                end
                else if (in_byte == jsu_pkg::CH_NUL)
                begin
                    cmd.main   = jsu_pkg::MAIN_ERR;
                    has_result = 1'b1;
                end
                else if (in_byte == jsu_pkg::CH_BSL)
                begin
                    phase_next = jsu_pkg::PH_ESC;
                end
                else
                begin
                    // raw bytes go out as they are, one word each
                    cmd.flush       = held_valid_reg;
                    cmd.flush_cp    = held_high_reg;
                    cmd.main        = jsu_pkg::MAIN_CP;
                    cmd.cp          = {13'd0, in_byte};
                    has_result      = 1'b1;
                    verbatim        = 1'b1;
                    held_high_next  = '0;
                    held_valid_next = 1'b0;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                if (in_byte == jsu_pkg::CH_U)
                begin
                    phase_next     = jsu_pkg::PH_HEX;
                    hex_value_next = '0;
                    hex_count_next = '0;
                end
                else if (!em[8])
                begin
                    cmd.main   = jsu_pkg::MAIN_ERR;
                    has_result = 1'b1;
                end
                else
                begin
                    cmd.flush       = held_valid_reg;
                    cmd.flush_cp    = held_high_reg;
                    cmd.main        = jsu_pkg::MAIN_CP;
                    cmd.cp          = {13'd0, em[7:0]};
                    has_result      = 1'b1;
                    phase_next      = jsu_pkg::PH_BODY;
                    held_high_next  = '0;
                    held_valid_next = 1'b0;
                end
            end
            jsu_pkg::PH_HEX:
            begin
                if (!hd[4])
                begin
                    cmd.main   = jsu_pkg::MAIN_ERR;
                    has_result = 1'b1;
                end
                else if (hex_count_reg == 3'd3)
                begin
                    phase_next     = jsu_pkg::PH_BODY;
                    hex_value_next = '0;
                    hex_count_next = '0;
                    if (held_valid_reg && v >= jsu_pkg::LO_SURR_LO && v <= jsu_pkg::LO_SURR_HI)
                    begin
                        // pair completes: one supplementary code point
                        cmd.main        = jsu_pkg::MAIN_CP;
                        cmd.cp          = jsu_pkg::SUPP_BASE
                                          + {1'b0, held_high_reg[9:0], v[9:0]};
                        has_result      = 1'b1;
                        held_high_next  = '0;
                        held_valid_next = 1'b0;
                    end
                    else
                    begin
                        cmd.flush    = held_valid_reg;
                        cmd.flush_cp = held_high_reg;
                        if (v >= jsu_pkg::HI_SURR_LO && v <= jsu_pkg::HI_SURR_HI)
                        begin
                            cmd.main        = jsu_pkg::MAIN_NONE;
                            has_result      = held_valid_reg;
                            held_high_next  = v;
                            held_valid_next = 1'b1;
                        end
                        else
                        begin
                            cmd.main        = jsu_pkg::MAIN_CP;
                            cmd.cp          = {5'd0, v};
                            has_result      = 1'b1;
                            held_high_next  = '0;
                            held_valid_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    hex_value_next = v;
                    hex_count_next = hex_count_reg + 3'd1;
                end
            end
            default:
            begin
                if (in_byte == jsu_pkg::CH_QUOTE)
                begin
                    phase_next = jsu_pkg::PH_BODY;
                end
                else
                begin
                    cmd.main   = jsu_pkg::MAIN_ERR;
                    has_result = 1'b1;
                end
            end
        endcase

        // any fault drops the whole state, held surrogate included
        if (cmd.main == jsu_pkg::MAIN_ERR)
        begin
            cmd.flush       = 1'b0;
            phase_next      = jsu_pkg::PH_IDLE;
            hex_value_next  = '0;
            hex_count_next  = '0;
            held_high_next  = '0;
            held_valid_next = 1'b0;
        end

        case (cmd.main)
            jsu_pkg::MAIN_CP:   cmd.cp_len = verbatim ? 3'd1 : jsu_pkg::utf8_len(cmd.cp);
            jsu_pkg::MAIN_NONE: cmd.cp_len = 3'd0;
            default:            cmd.cp_len = 3'd1;
        endcase
        cmd.total = cmd.cp_len + (cmd.flush ? 3'd3 : 3'd0);
    end

    assign cmd_push = accept && has_result;
    assign status   = '{phase: phase_reg, held_valid: held_valid_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= jsu_pkg::PH_IDLE;
            hex_value_reg  <= '0;
            hex_count_reg  <= '0;
            held_high_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            hex_value_reg  <= hex_value_next;
            hex_count_reg  <= hex_count_next;
            held_high_reg  <= held_high_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

// ----- rtl/jsu_cmd_fifo.sv -----
// Short command queue between the front end and the byte expander.
module jsu_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  jsu_pkg::cmd_t wr_data,
    input  logic          rd,
    output jsu_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);

    jsu_pkg::cmd_t                  slot_reg [jsu_pkg::CMD_DEPTH];
    logic [jsu_pkg::CMD_PTR_W-1:0] wr_ptr_reg;
    logic [jsu_pkg::CMD_PTR_W-1:0] rd_ptr_reg;
    logic [jsu_pkg::CMD_CNT_W-1:0] count_reg;
    logic                          do_wr;
    logic                          do_rd;

    assign full    = (count_reg == jsu_pkg::CMD_CNT_W'(jsu_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/jsu_back.sv -----
// Back end: expands one command into its result words, one word per cycle while pop is held.
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  jsu_pkg::cmd_t head,
    input  logic          head_empty,
    output logic          head_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_byte,
    output logic [1:0]    kind,
    output logic          last
);

    jsu_pkg::cmd_t cur_reg;
    logic          cur_valid_reg;
    logic [2:0]    step_reg;
    logic [2:0]    j;
    logic          taken;

    assign empty    = !cur_valid_reg;
    assign last     = (step_reg == cur_reg.total - 3'd1);
    assign taken    = pop && cur_valid_reg;
    assign head_pop = !head_empty && (!cur_valid_reg || (taken && last));

    always_comb
    begin
        j        = step_reg - (cur_reg.flush ? 3'd3 : 3'd0);
        out_byte = 8'd0;
        kind     = jsu_pkg::KIND_DATA;
        if (cur_reg.flush && step_reg < 3'd3)
        begin
            // unpaired high surrogate, always three bytes
            out_byte = jsu_pkg::utf8_byte({5'd0, cur_reg.flush_cp}, 3'd3, step_reg[1:0]);
        end
        else
        begin
            case (cur_reg.main)
                jsu_pkg::MAIN_END: kind = jsu_pkg::KIND_END;
                jsu_pkg::MAIN_ERR: kind = jsu_pkg::KIND_ERR;
                default:
                    out_byte = jsu_pkg::utf8_byte(cur_reg.cp, cur_reg.cp_len, j[1:0]);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
            cur_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else if (head_pop)
        begin
            cur_valid_reg <= 1'b1;
            step_reg      <= '0;
        end
        else if (taken && last)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (taken)
        begin
            step_reg <= step_reg + 3'd1;
        end
    end

endmodule
